@@ hw/rtl/mkdc_pkg.sv @@
// Shared types and constants for the multi-key dispatch cache.
`default_nettype none
package mkdc_pkg;
    localparam int unsigned ARG_W = 64;
    localparam int unsigned ARGS  = 4;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_FILLED  = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_BYPASS  = 3'd4;

    localparam logic [7:0] CFG_KEY_COUNT  = 8'd0;
    localparam logic [7:0] CFG_KEY_MODES  = 8'd1;
    localparam logic [7:0] CFG_TABLE_SIZE = 8'd2;

    localparam logic [1:0] MODE_IGNORE = 2'd0;
    localparam logic [1:0] MODE_KIND   = 2'd1;

    localparam logic ACT_LOOKUP = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PRB_RD,
        S_PRB_CMP,
        S_RESP
    } t_state;
endpackage
`default_nettype wire

@@ hw/rtl/mkdc_hash.sv @@
// Key hash fold, one key per cycle, then modulo table size, four bits per cycle.
`default_nettype none
module mkdc_hash
    import mkdc_pkg::*;
#(
    parameter int unsigned KEYS = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [ARG_W-1:0] i_keys [KEYS],
    input  wire logic [2:0]       i_count,
    input  wire logic [4:0]       i_size,
    output logic                  o_done,
    output logic [4:0]            o_home
);
    localparam int unsigned KIW = (KEYS > 1) ? $clog2(KEYS) : 1;

    logic             r_busy, n_busy;
    logic             r_mod, n_mod;
    logic [2:0]       r_k, n_k;
    logic [3:0]       r_cnt, n_cnt;
    logic [ARG_W-1:0] r_h, n_h;
    logic [5:0]       r_rem, n_rem;
    logic             r_done, n_done;

    logic [ARG_W-1:0] key, x, hk;
    logic [5:0]       rem;

    always_comb begin
        key = i_keys[r_k[KIW-1:0]];
        x   = (key << 3) + (key << 2) + key;
        x   = x ^ (key >> 12);
        hk  = (x << 3) + (x << 1) + x;
        rem = r_rem;
        for (int b = 0; b < 4; b++) begin
            rem = {rem[4:0], r_h[ARG_W-1-b]};
            if (rem >= {1'b0, i_size}) begin
                rem = rem - {1'b0, i_size};
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_mod  = r_mod;
        n_k    = r_k;
        n_cnt  = r_cnt;
        n_h    = r_h;
        n_rem  = r_rem;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_mod  = 1'b0;
            n_k    = 3'd0;
            n_h    = '0;
            n_rem  = '0;
            n_cnt  = '0;
        end else if (r_busy && !r_mod) begin
            if (r_k < i_count) begin
                n_h = (r_h << 4) + r_h + hk;
                n_k = r_k + 3'd1;
            end else begin
                n_mod = 1'b1;
            end
        end else if (r_busy) begin
            n_rem = rem;
            n_h   = r_h << 4;
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mod  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_mod  <= n_mod;
            r_done <= n_done;
        end
        r_k   <= n_k;
        r_cnt <= n_cnt;
        r_h   <= n_h;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_home = r_rem[4:0];
endmodule
`default_nettype wire

@@ hw/rtl/multi_key_dispatch_cache.sv @@
// Multi-key dispatch cache: hashed open-addressing table with linear probing.
// Fill and bypass beats pass through the result registers to the output register.
// Lookup: hash fold of the keys, modulo (four bits a cycle), then probing with a read
// per free slot and a read and compare per occupied slot; one beat in flight at a time.
// Reset (synchronous, active low) clears configuration, entry valid bits and the
// reservation; a configuration write to index 0 to 2 clears the valid bits and reservation too.
`default_nettype none
module multi_key_dispatch_cache
    import mkdc_pkg::*;
#(
    parameter int unsigned KEYS    = 4,
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // arg_object_0..3, arg_kind_0..3, fill_method
    input  wire logic [575:0] s_axis_tdata,
    // action
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // method_out, slot, zero pad
    output logic [71:0]       m_axis_tdata,
    // status
    output logic [2:0]        m_axis_tuser
);
    localparam int unsigned DEPTH = (ENTRIES < 31) ? ENTRIES : 31;
    localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned KW    = KEYS * ARG_W;

    t_state r_state, n_state;

    logic [2:0] r_key_count;
    logic [7:0] r_key_modes;
    logic [4:0] r_table_size;

    logic [DEPTH-1:0] r_valid;
    logic [IW-1:0]    mem_hash   [DEPTH];
    logic [KW-1:0]    mem_keys   [DEPTH];
    logic [ARG_W-1:0] mem_method [DEPTH];
    logic [IW-1:0]    r_rd_hash;
    logic [KW-1:0]    r_rd_keys;
    logic [ARG_W-1:0] r_rd_method;

    logic             r_pend_valid;
    logic [IW-1:0]    r_pend_slot, r_pend_hash;
    logic [KW-1:0]    r_pend_keys;

    logic [ARG_W-1:0] r_keys [KEYS];
    logic [ARG_W-1:0] in_keys [KEYS];
    logic [IW-1:0]    r_home, r_s;
    logic [4:0]       r_i;

    logic [2:0]       r_res_status;
    logic [ARG_W-1:0] r_res_method;
    logic [IW-1:0]    r_res_slot;

    logic             r_out_valid;
    logic [2:0]       r_out_status;
    logic [ARG_W-1:0] r_out_method;
    logic [3:0]       r_out_slot;

    logic [2:0]  count;
    logic [4:0]  size;
    logic        in_beat, cfg_beat, hash_start, hash_done, rd_en, match, out_load;
    logic [4:0]  hash_home;
    logic [5:0]  s_next;
    logic [31:0] slot_w;
    logic [ARG_W-1:0] fill_method;
    logic [KW-1:0] cur_keys;

    assign count = (r_key_count > 3'(KEYS)) ? 3'(KEYS) : r_key_count;
    assign size  = (r_table_size > 5'(DEPTH)) ? 5'(DEPTH) : r_table_size;
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign cfg_beat = i_cfg_valid && o_cfg_ready;
    assign fill_method = s_axis_tdata[8*ARG_W +: ARG_W];
    assign s_next = {{(6-IW){1'b0}}, r_s} + 6'd1;

    always_comb begin
        for (int i = 0; i < KEYS; i++) begin
            logic [1:0] mode;
            mode = r_key_modes[2*i +: 2];
            if (3'(i) >= count || mode == MODE_IGNORE) begin
                in_keys[i] = '0;
            end else if (mode == MODE_KIND) begin
                in_keys[i] = s_axis_tdata[(ARGS+i)*ARG_W +: ARG_W];
            end else begin
                in_keys[i] = s_axis_tdata[i*ARG_W +: ARG_W];
            end
            cur_keys[i*ARG_W +: ARG_W] = r_keys[i];
        end
    end

    always_comb begin
        match = (r_rd_hash == r_home);
        for (int j = 0; j < KEYS; j++) begin
            if (3'(j) < count && r_rd_keys[j*ARG_W +: ARG_W] != r_keys[j]) begin
                match = 1'b0;
            end
        end
    end

    mkdc_hash #(.KEYS(KEYS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_keys  (r_keys),
        .i_count (count),
        .i_size  (size),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = (s_axis_tuser[0] == ACT_LOOKUP && size != 5'd0) ? S_HASH
                                                                               : S_RESP;
                end
            end
            S_HASH:    if (hash_done) n_state = S_PRB_RD;
            S_PRB_RD:  n_state = r_valid[r_s] ? S_PRB_CMP : S_RESP;
            S_PRB_CMP: begin
                if (match || (r_i + 5'd1) == size) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_PRB_RD;
                end
            end
            S_RESP:    if (out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        hash_start    = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE:    hash_start = in_beat && s_axis_tuser[0] == ACT_LOOKUP && size != 5'd0;
            S_PRB_RD:  rd_en = r_valid[r_s];
            S_RESP:    out_load = !r_out_valid || m_axis_tready;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_hash   <= mem_hash[r_s];
            r_rd_keys   <= mem_keys[r_s];
            r_rd_method <= mem_method[r_s];
        end
        if (in_beat && s_axis_tuser[0] != ACT_LOOKUP && size != 5'd0 && r_pend_valid
                && fill_method != '0) begin
            mem_hash[r_pend_slot]   <= r_pend_hash;
            mem_keys[r_pend_slot]   <= r_pend_keys;
            mem_method[r_pend_slot] <= fill_method;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key_count  <= '0;
            r_key_modes  <= '0;
            r_table_size <= '0;
            r_valid      <= '0;
            r_pend_valid <= 1'b0;
            r_pend_slot  <= '0;
            r_pend_hash  <= '0;
            r_pend_keys  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_beat && i_cfg_index <= CFG_TABLE_SIZE) begin
                unique case (i_cfg_index)
                    CFG_KEY_COUNT: r_key_count  <= i_cfg_data[2:0];
                    CFG_KEY_MODES: r_key_modes  <= i_cfg_data;
                    default:       r_table_size <= i_cfg_data[4:0];
                endcase
                r_valid      <= '0;
                r_pend_valid <= 1'b0;
                r_pend_slot  <= '0;
                r_pend_hash  <= '0;
                r_pend_keys  <= '0;
            end
            if (in_beat && s_axis_tuser[0] != ACT_LOOKUP) begin
                if (size != 5'd0 && r_pend_valid) begin
                    r_pend_valid <= 1'b0;
                    if (fill_method != '0) r_valid[r_pend_slot] <= 1'b1;
                end
            end else if (in_beat && size == 5'd0) begin
                r_pend_valid <= 1'b0;
            end
            if (r_state == S_PRB_RD && !r_valid[r_s]) begin
                r_pend_valid <= 1'b1;
                r_pend_slot  <= r_s;
                r_pend_hash  <= r_home;
                r_pend_keys  <= cur_keys;
            end
            if (r_state == S_PRB_CMP) begin
                if (match) begin
                    r_pend_valid <= 1'b0;
                end else if ((r_i + 5'd1) == size) begin
                    r_pend_valid <= 1'b1;
                    r_pend_slot  <= r_home;
                    r_pend_hash  <= r_home;
                    r_pend_keys  <= cur_keys;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign slot_w = 32'(r_res_slot);

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_keys       <= in_keys;
            r_res_method <= '0;
            r_res_slot   <= '0;
            if (s_axis_tuser[0] != ACT_LOOKUP) begin
                r_res_status <= ST_IGNORED;
                if (size != 5'd0 && r_pend_valid) begin
                    r_res_slot <= r_pend_slot;
                    if (fill_method != '0) r_res_status <= ST_FILLED;
                end
            end else begin
                r_res_status <= ST_BYPASS;
            end
        end
        if (hash_done) begin
            r_home <= hash_home[IW-1:0];
            r_s    <= hash_home[IW-1:0];
            r_i    <= '0;
        end
        if (r_state == S_PRB_RD && !r_valid[r_s]) begin
            r_res_status <= ST_MISS;
            r_res_slot   <= r_s;
        end
        if (r_state == S_PRB_CMP) begin
            if (match) begin
                r_res_status <= ST_HIT;
                r_res_method <= r_rd_method;
                r_res_slot   <= r_s;
            end else if ((r_i + 5'd1) == size) begin
                r_res_status <= ST_MISS;
                r_res_slot   <= r_home;
            end else begin
                r_i <= r_i + 5'd1;
                r_s <= (s_next == {1'b0, size}) ? '0 : s_next[IW-1:0];
            end
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_method <= r_res_method;
            r_out_slot   <= slot_w[3:0];
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'd0, r_out_slot, r_out_method};

`ifndef SYNTH
    a_hit_drops_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRB_CMP && match) |=> !r_pend_valid)
        else $error("hit left reservation");
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_beat && i_cfg_index <= CFG_TABLE_SIZE) |=> (r_valid == '0 && !r_pend_valid))
        else $error("config write did not clear table");
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRB_RD || r_state == S_PRB_CMP) |-> ({1'b0, r_s} < 6'(size)))
        else $error("probe slot out of range");
`endif
endmodule
`default_nettype wire
